// File: design/irpwfe_pkg.sv
// Shared types, constants and codes of the pulse-width IR frame encoder.
package irpwfe_pkg;

	localparam int MAX_BITS = 32;
	localparam int CNT_W    = $clog2(MAX_BITS + 1);
	localparam int LEN_W    = 16;
	localparam int WORD_W   = 32;
	localparam int BC_W     = 6;
	localparam int IDX_W    = 2;

	localparam logic [LEN_W-1:0] HEADER_MARK_RST  = 16'd3000;
	localparam logic [LEN_W-1:0] HEADER_SPACE_RST = 16'd1000;
	localparam logic [LEN_W-1:0] ONE_MARK_RST     = 16'd1200;
	localparam logic [LEN_W-1:0] ZERO_MARK_RST    = 16'd600;

	localparam logic [IDX_W-1:0] REG_HEADER_MARK  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEADER_SPACE = 2'd1;
	localparam logic [IDX_W-1:0] REG_ONE_MARK     = 2'd2;
	localparam logic [IDX_W-1:0] REG_ZERO_MARK    = 2'd3;

	localparam logic [1:0] SYM_HEADER  = 2'd0;
	localparam logic [1:0] SYM_BIT     = 2'd1;
	localparam logic [1:0] SYM_TRAILER = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] payload;
		logic [BC_W-1:0]   bit_count;
	} req_beat_t;

	typedef struct packed {
		logic [LEN_W-1:0] mark_len;
		logic [LEN_W-1:0] space_len;
		logic             last;
	} sym_beat_t;

	typedef struct packed {
		logic       load;
		logic       emit;
		logic [1:0] kind;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic last_bit;
	} dp_status_t;

endpackage

// File: design/ir_pulse_width_frame_encoder_core.sv
// Top level of the pulse-width IR frame encoder.
//
// Request channel (req_valid, req_stall, req): one beat carries a data word
// and a bit count. Counts of zero send one bit; counts above MAX_BITS send
// MAX_BITS. The low bits of the word are sent most significant first.
// Symbol channel (sym_valid, sym_stall, sym): one beat per symbol, in the
// order header, one beat per data bit, trailer; the trailer has no space and
// carries last. A frame of n bits gives n + 2 beats.
// The request is taken in the idle state and the header beat is loaded in the
// header state; further symbols follow one per cycle from a single output
// register while the symbol channel is not stalled. The sequencer takes one
// frame at a time: the next request is taken in the cycle after the trailer
// is loaded.
// A stall on the symbol channel holds the current beat and keeps the sequencer
// from loading another symbol over it; no symbol is lost. Timing registers are
// written through cfg_we, cfg_index, cfg_data; the user writes them only while
// the block is idle; the block does not enforce this. Reset idles the sequencer,
// empties the output register, restores default timings (3000, 1000, 1200, 600).
module ir_pulse_width_frame_encoder_core
	import irpwfe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_beat_t        req,
	output logic             sym_valid,
	input  logic             sym_stall,
	output sym_beat_t        sym,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       idle;

	irpwfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd),
		.idle      (idle)
	);

	irpwfe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.sym       (sym)
	);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while a frame is pending");

	a_trailer_no_space: assert property (@(posedge clk) disable iff (!arst_n)
		(sym_valid && sym.last) |-> (sym.space_len == '0))
		else $error("trailer beat carries a space");

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.slot_free)
		else $error("symbol loaded over an untaken beat");

	a_idle_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> !cmd.emit)
		else $error("symbol emitted while idle");

endmodule

// File: design/irpwfe_ctrl.sv
// Frame sequencer: idle, header, data bits, trailer.
module irpwfe_ctrl
	import irpwfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       idle
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_HEADER  = 2'd1;
	localparam logic [1:0] ST_BITS    = 2'd2;
	localparam logic [1:0] ST_TRAILER = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign idle      = (state_q == ST_IDLE);
	assign req_stall = !idle;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		cmd.kind = SYM_HEADER;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_HEADER;
				end
			end
			ST_HEADER: begin
				cmd.kind = SYM_HEADER;
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_BITS;
				end
			end
			ST_BITS: begin
				cmd.kind = SYM_BIT;
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					if (status.last_bit) begin
						state_d = ST_TRAILER;
					end
				end
			end
			ST_TRAILER: begin
				cmd.kind = SYM_TRAILER;
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/irpwfe_dp.sv
// Datapath: timing registers, shift word, bit counter and output beat register.
module irpwfe_dp
	import irpwfe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  req_beat_t        req,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0] cfg_data,
	input  dp_cmd_t          cmd,
	output dp_status_t       status,
	output logic             sym_valid,
	input  logic             sym_stall,
	output sym_beat_t        sym
);

	logic [LEN_W-1:0]  header_mark_q;
	logic [LEN_W-1:0]  header_space_q;
	logic [LEN_W-1:0]  one_mark_q;
	logic [LEN_W-1:0]  zero_mark_q;
	logic [WORD_W-1:0] word_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_init;
	logic [CNT_W-1:0]  pos;
	logic [31:0]       pos_ext;
	logic              cur_bit;
	logic              valid_q;
	sym_beat_t         sym_q;
	sym_beat_t         sym_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_mark_q  <= HEADER_MARK_RST;
			header_space_q <= HEADER_SPACE_RST;
			one_mark_q     <= ONE_MARK_RST;
			zero_mark_q    <= ZERO_MARK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER_MARK:  header_mark_q  <= cfg_data;
				REG_HEADER_SPACE: header_space_q <= cfg_data;
				REG_ONE_MARK:     one_mark_q     <= cfg_data;
				REG_ZERO_MARK:    zero_mark_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (req.bit_count == '0) begin
			cnt_init = CNT_W'(1);
		end else if (32'(req.bit_count) > 32'(MAX_BITS)) begin
			cnt_init = CNT_W'(MAX_BITS);
		end else begin
			cnt_init = CNT_W'(req.bit_count);
		end
	end

	assign pos     = cnt_q - CNT_W'(1);
	assign pos_ext = 32'(pos);
	assign cur_bit = (pos_ext < 32'(WORD_W)) ? word_q[pos_ext[4:0]] : 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= cnt_init;
		end else if (cmd.emit && (cmd.kind == SYM_BIT)) begin
			cnt_q <= pos;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= req.payload;
		end
	end

	always_comb begin
		unique case (cmd.kind)
			SYM_HEADER: begin
				sym_d.mark_len  = header_mark_q;
				sym_d.space_len = header_space_q;
				sym_d.last      = 1'b0;
			end
			SYM_BIT: begin
				sym_d.mark_len  = cur_bit ? one_mark_q : zero_mark_q;
				sym_d.space_len = header_space_q;
				sym_d.last      = 1'b0;
			end
			SYM_TRAILER: begin
				sym_d.mark_len  = zero_mark_q;
				sym_d.space_len = '0;
				sym_d.last      = 1'b1;
			end
			default: begin
				sym_d.mark_len  = zero_mark_q;
				sym_d.space_len = '0;
				sym_d.last      = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (!sym_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sym_q <= sym_d;
		end
	end

	assign status.slot_free = !valid_q || !sym_stall;
	assign status.last_bit  = (cnt_q == CNT_W'(1));
	assign sym_valid        = valid_q;
	assign sym              = sym_q;

endmodule
